@@ rtl/mac_learning_cache_defines.svh @@
// ----------------------------------------------------------------------------
// mac learning cache assertion macros
// shared concurrent assertion wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_CACHE_DEFINES_SVH
`define MAC_LEARNING_CACHE_DEFINES_SVH

// checked only outside reset
`define MLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mlc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlc_pkg
// types and constants of the mac learning cache
// ----------------------------------------------------------------------------
package mlc_pkg;

    typedef enum logic {
        OP_LEARN  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_AGED      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SCAN,
        ST_WB
    } state_t;

    // one way of a set, mac of zero marks a blank way
    typedef struct packed {
        logic [47:0] mac;
        logic [15:0] vlan;
        logic [11:0] port;
        logic [31:0] stamp;
    } way_t;

    localparam int          WAY_BITS        = $bits(way_t);
    localparam int          MCAST_POS       = 40;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd4500;

endpackage

@@ rtl/mlc_set_ram.sv @@
// ----------------------------------------------------------------------------
// mlc_set_ram
// one-row-per-set memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mlc_set_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int WIDTH  = 540
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mlc_hash.sv @@
// ----------------------------------------------------------------------------
// mlc_hash
// set index from the xor of the three 16-bit mac slices, modulo the set count
// ----------------------------------------------------------------------------
module mlc_hash #(
    parameter int SET_COUNT = 4096,
    parameter int IDX_W     = 12
) (
    input  logic             clk,
    input  logic             load,
    input  logic [47:0]      mac,
    output logic [IDX_W-1:0] set_idx
);

    // ceil(2^32 / SET_COUNT), exact quotient for any 16-bit fold
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) + 64'(SET_COUNT) - 64'd1) / 33'(SET_COUNT);

    logic [15:0] fold;
    logic [15:0] fold_reg;
    logic [48:0] prod_reg;
    logic [15:0] quot;
    logic [32:0] quot_mul;
    logic [16:0] rem_full;

    assign fold = mac[47:32] ^ mac[31:16] ^ mac[15:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fold_reg <= fold;
            prod_reg <= 49'(fold) * 49'(RECIP);
        end
    end

    assign quot     = prod_reg[47:32];
    assign quot_mul = 33'(quot) * 33'(SET_COUNT);
    assign rem_full = 17'(fold_reg) - quot_mul[16:0];
    assign set_idx  = rem_full[IDX_W-1:0];

endmodule

@@ rtl/mac_learning_cache.sv @@
// ----------------------------------------------------------------------------
// mac_learning_cache
// hashed set-associative mac learning table with aging on lookup
// ----------------------------------------------------------------------------
// After reset the block sweeps the set memory to blank, one set per cycle, with
// in_ready low until every set is cleared; age_limit writes are taken meanwhile.
// Each item is a read-modify-write of one set row in the single set memory:
// read, evaluate, write back, and the next item is taken in the write-back
// cycle once the output register is free. A learn that misses in a full set scans
// the ways one at a time to find the oldest entry with a shared age comparator.
// The result waits in an output register while the next item is worked on.
module mac_learning_cache
    import mlc_pkg::*;
#(
    parameter int SET_COUNT = 4096,
    parameter int WAY_COUNT = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [47:0] mac_address,
    input  logic [15:0] vlan_if,
    input  logic [11:0] port,
    input  logic [31:0] now_tick,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [11:0] out_port,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int IDX_W = $clog2(SET_COUNT);
    localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int ROW_W = WAY_COUNT * WAY_BITS;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            clr_reg, clr_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [WAY_W-1:0]            scan_reg, scan_next;
    logic [31:0]                 best_age_reg, best_age_next;
    logic [WAY_W-1:0]            best_way_reg, best_way_next;
    logic                        hit_reg, hit_next;
    logic [WAY_W-1:0]            hit_way_reg, hit_way_next;
    logic                        blank_reg, blank_next;
    logic [WAY_W-1:0]            blank_way_reg, blank_way_next;
    way_t [WAY_COUNT-1:0]        row_reg, row_next;
    logic                        out_valid_reg, out_valid_next;
    status_t                     status_reg, status_next;
    logic [11:0]                 out_port_reg, out_port_next;
    logic [31:0]                 age_limit_reg;

    op_t                         op_reg;
    logic [47:0]                 mac_reg;
    logic [15:0]                 vlan_reg;
    logic [11:0]                 port_reg;
    logic [31:0]                 now_reg;

    logic                        in_xfer;
    logic [IDX_W-1:0]            set_idx;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [ROW_W-1:0]            ram_wdata;
    logic                        ram_re;
    logic [ROW_W-1:0]            ram_rdata;
    way_t [WAY_COUNT-1:0]        rd_row;

    logic                        hit_c;
    logic [WAY_W-1:0]            hit_way_c;
    logic                        blank_c;
    logic [WAY_W-1:0]            blank_way_c;
    logic                        learn_ok;
    logic [31:0]                 scan_age;
    logic [31:0]                 hit_age;
    way_t [WAY_COUNT-1:0]        wb_row;
    logic                        wb_we;
    status_t                     wb_status;
    logic [11:0]                 wb_port;
    logic [WAY_W-1:0]            slot;
    logic                        out_free;

    assign in_xfer = in_valid && in_ready;

    mlc_hash #(
        .SET_COUNT (SET_COUNT),
        .IDX_W     (IDX_W)
    ) u_hash (
        .clk     (clk),
        .load    (in_xfer),
        .mac     (mac_address),
        .set_idx (set_idx)
    );

    mlc_set_ram #(
        .DEPTH  (SET_COUNT),
        .ADDR_W (IDX_W),
        .WIDTH  (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    // match and first blank, lowest way wins
    always_comb
    begin
        hit_c       = 1'b0;
        hit_way_c   = '0;
        blank_c     = 1'b0;
        blank_way_c = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (mac_reg != '0 && rd_row[w].mac == mac_reg && rd_row[w].vlan == vlan_reg)
            begin
                hit_c     = 1'b1;
                hit_way_c = WAY_W'(w);
            end
            if (rd_row[w].mac == '0)
            begin
                blank_c     = 1'b1;
                blank_way_c = WAY_W'(w);
            end
        end
    end

    assign learn_ok = !mac_reg[MCAST_POS] && (mac_reg != '0);
    assign scan_age = now_reg - row_reg[scan_reg].stamp;
    assign hit_age  = now_reg - row_reg[hit_way_reg].stamp;
    assign slot     = blank_reg ? blank_way_reg : best_way_reg;

    // write-back row and result of the item in hand
    always_comb
    begin
        wb_row    = row_reg;
        wb_we     = 1'b0;
        wb_status = STATUS_OK;
        wb_port   = '0;
        if (op_reg == OP_LEARN)
        begin
            priority if (!learn_ok)
            begin
                wb_status = STATUS_INVALID;
            end
            else if (hit_reg)
            begin
                wb_row[hit_way_reg].port  = port_reg;
                wb_row[hit_way_reg].stamp = now_reg;
                wb_we                     = 1'b1;
            end
            else
            begin
                wb_row[slot] = '{mac: mac_reg, vlan: vlan_reg, port: port_reg, stamp: now_reg};
                wb_we        = 1'b1;
            end
        end
        else
        begin
            priority if (!hit_reg)
            begin
                wb_status = STATUS_NOT_FOUND;
            end
            else if (hit_age > age_limit_reg)
            begin
                // only the mac is blanked, the rest of the way stays
                wb_row[hit_way_reg].mac = '0;
                wb_we                   = 1'b1;
                wb_status               = STATUS_AGED;
            end
            else
            begin
                wb_port = row_reg[hit_way_reg].port;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        best_age_next  = best_age_reg;
        best_way_next  = best_way_reg;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        blank_next     = blank_reg;
        blank_way_next = blank_way_reg;
        row_next       = row_reg;
        status_next    = status_reg;
        out_port_next  = out_port_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = wb_row;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                idx_next   = set_idx;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                row_next       = rd_row;
                hit_next       = hit_c;
                hit_way_next   = hit_way_c;
                blank_next     = blank_c;
                blank_way_next = blank_way_c;
                scan_next      = '0;
                best_age_next  = '0;
                best_way_next  = '0;
                if (op_reg == OP_LEARN && learn_ok && !hit_c && !blank_c)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_SCAN:
            begin
                // strict compare keeps the lower way on a tie
                if (scan_age > best_age_reg)
                begin
                    best_age_next = scan_age;
                    best_way_next = scan_reg;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == WAY_W'(WAY_COUNT - 1))
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    // write lands before the next item's read is issued
                    ram_we         = wb_we;
                    out_valid_next = 1'b1;
                    status_next    = wb_status;
                    out_port_next  = wb_port;
                    in_ready       = 1'b1;
                    state_next     = in_valid ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        best_age_reg  <= best_age_next;
        best_way_reg  <= best_way_next;
        hit_reg       <= hit_next;
        hit_way_reg   <= hit_way_next;
        blank_reg     <= blank_next;
        blank_way_reg <= blank_way_next;
        row_reg       <= row_next;
        status_reg    <= status_next;
        out_port_reg  <= out_port_next;
        if (in_xfer)
        begin
            op_reg   <= op_t'(op);
            mac_reg  <= mac_address;
            vlan_reg <= vlan_if;
            port_reg <= port;
            now_reg  <= now_tick;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_port  = out_port_reg;

endmodule

@@ rtl/mlc_checker.sv @@
// ----------------------------------------------------------------------------
// mlc_checker
// port-level checks of the mac learning cache, bound to the top level
// ----------------------------------------------------------------------------
`include "mac_learning_cache_defines.svh"

module mlc_checker
    import mlc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [11:0] out_port
);

    // items taken but not yet delivered
    logic [1:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    `MLC_ASSERT(a_no_result_without_item, out_valid |-> pend_reg != 2'd0, "result with no item pending")
    `MLC_ASSERT(a_two_items_at_most, in_xfer && pend_reg == 2'd2 |-> out_xfer, "third item taken")
    `MLC_ASSERT(a_port_zero_unless_ok, out_valid && status != STATUS_OK |-> out_port == 12'd0, "port on failed result")
    `MLC_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_port), "stalled result changed")
    `MLC_ASSERT_ALWAYS(a_clear_after_reset, $rose(rst_n) |-> !in_ready, "input taken during clearing pass")

endmodule

bind mac_learning_cache mlc_checker u_mlc_checker (.*);
